FILE: rtl/urm_pkg.sv
// urm_pkg: shared constants, types and helpers for the ultrasonic range median block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package urm_pkg;

  localparam int GROUP_SIZE_DEF  = 5;
  localparam int DIST_W          = 9;
  localparam int WIDTH_W         = 15;
  localparam int ECHO_TIMEOUT_US = 30000;
  localparam int MAX_DIST_RESET  = 250;
  localparam int MAX_DIST_CEIL   = 510;

  // floor(w / 58) == (w * 18079) >> 20 for every w below 174762
  localparam int CM_RECIP    = 18079;
  localparam int RECIP_W     = 15;
  localparam int RECIP_SHIFT = 20;
  localparam int QUOT_W      = 10;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  typedef logic [DIST_W-1:0]  dist_t;
  typedef logic [WIDTH_W-1:0] width_t;

  function automatic dist_t eff_max(input dist_t m);
    return (m > dist_t'(MAX_DIST_CEIL)) ? dist_t'(MAX_DIST_CEIL) : m;
  endfunction

endpackage

FILE: rtl/ultrasonic_range_median.sv
// ultrasonic_range_median: top level with the APB register and the filter pipeline.
// Depends on urm_pkg, urm_conv, urm_group and urm_median.
//
// Usage:
//   Input channel (in_valid/in_ready, echo_width_us) carries one echo width in us
//   per word; 0 means no echo. Each width becomes a distance in cm; no echo, a
//   width above 30000 us or a distance above dist_limit becomes limit + 1.
//   After every GROUP_SIZE-th accepted word the output channel (out_valid/
//   out_ready) carries one word: the median of the group and out_of_range.
//   Throughput: one input word per cycle, set by the three register stages
//   (input register, group snapshot, output register) each passing a word per cycle
//   while no receiver stall backs up; results are valid from the output register.
//   When the receiver stalls, the result holds in the output register while the
//   following group keeps filling; input stalls only once a finished group waits
//   in the snapshot register and the next group's last word arrives.
//   Reset clears the fill count and all valid flags and sets dist_limit to 250.
//   dist_limit sits at APB address 0 (bits 8:0); limits above 510 act as 510.
`timescale 1ns / 1ps

module ultrasonic_range_median #(
  parameter int GROUP_SIZE = urm_pkg::GROUP_SIZE_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [urm_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [urm_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [urm_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  urm_pkg::width_t                   echo_width_us,
  output logic                              out_valid,
  input  logic                              out_ready,
  output urm_pkg::dist_t                    median_cm,
  output logic                              out_of_range
);
  import urm_pkg::*;

  typedef enum logic [0:0] {
    REG_MAX_DIST = 1'b0,
    REG_UNUSED   = 1'b1
  } reg_idx_t;

  dist_t                  dist_limit;
  dist_t                  lim;
  reg_idx_t               reg_idx;
  logic                   smp_valid;
  logic                   smp_ready;
  dist_t                  smp_data;
  logic                   grp_valid;
  logic                   grp_ready;
  dist_t [GROUP_SIZE-1:0] grp_data;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_limit <= dist_t'(MAX_DIST_RESET);
    end else if (psel && penable && pwrite && reg_idx == REG_MAX_DIST) begin
      dist_limit <= pwdata[DIST_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MAX_DIST: prdata = APB_DATA_W'(dist_limit);
      default:      prdata = '0;
    endcase
  end

  assign lim = eff_max(dist_limit);

  urm_conv u_conv (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .echo_width_us (echo_width_us),
    .lim           (lim),
    .smp_valid     (smp_valid),
    .smp_ready     (smp_ready),
    .smp_data      (smp_data)
  );

  urm_group #(.GROUP_SIZE(GROUP_SIZE)) u_group (
    .clk       (clk),
    .rst       (rst),
    .smp_valid (smp_valid),
    .smp_ready (smp_ready),
    .smp_data  (smp_data),
    .grp_valid (grp_valid),
    .grp_ready (grp_ready),
    .grp_data  (grp_data)
  );

  urm_median #(.GROUP_SIZE(GROUP_SIZE)) u_median (
    .clk          (clk),
    .rst          (rst),
    .grp_valid    (grp_valid),
    .grp_ready    (grp_ready),
    .grp_data     (grp_data),
    .lim          (lim),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .median_cm    (median_cm),
    .out_of_range (out_of_range)
  );

endmodule

FILE: rtl/urm_conv.sv
// urm_conv: input register and echo-width to centimetre conversion.
// Depends on urm_pkg.
`timescale 1ns / 1ps

module urm_conv (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  urm_pkg::width_t echo_width_us,
  input  urm_pkg::dist_t lim,
  output logic           smp_valid,
  input  logic           smp_ready,
  output urm_pkg::dist_t smp_data
);
  import urm_pkg::*;

  localparam int PROD_W = WIDTH_W + RECIP_W;

  width_t             w_reg;
  logic               v_reg;
  logic [PROD_W-1:0]  prod;
  logic [QUOT_W-1:0]  quot;
  dist_t              sentinel;

  assign in_ready  = !v_reg || smp_ready;
  assign smp_valid = v_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_reg <= 1'b0;
    end else if (in_ready) begin
      v_reg <= in_valid;
    end
    if (in_ready && in_valid) begin
      w_reg <= echo_width_us;
    end
  end

  assign prod     = PROD_W'(w_reg) * PROD_W'(CM_RECIP);
  assign quot     = prod[RECIP_SHIFT +: QUOT_W];
  assign sentinel = lim + dist_t'(1);

  always_comb begin
    if (w_reg == '0 || w_reg > width_t'(ECHO_TIMEOUT_US)) begin
      smp_data = sentinel;
    end else if (quot > {1'b0, lim}) begin
      smp_data = sentinel;
    end else begin
      smp_data = quot[DIST_W-1:0];
    end
  end

endmodule

FILE: rtl/urm_group.sv
// urm_group: sample store, fill count and group snapshot register.
// Depends on urm_pkg.
`timescale 1ns / 1ps

module urm_group #(
  parameter int GROUP_SIZE = urm_pkg::GROUP_SIZE_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                smp_valid,
  output logic                                smp_ready,
  input  urm_pkg::dist_t                      smp_data,
  output logic                                grp_valid,
  input  logic                                grp_ready,
  output urm_pkg::dist_t [GROUP_SIZE-1:0]     grp_data
);
  import urm_pkg::*;

  localparam int CNT_W = $clog2(GROUP_SIZE);

  dist_t [GROUP_SIZE-2:0] store;
  logic  [CNT_W-1:0]      fill_count;
  logic                   last;
  logic                   slot_free;
  logic                   take;

  assign last      = (fill_count == CNT_W'(GROUP_SIZE - 1));
  assign slot_free = !grp_valid || grp_ready;
  assign smp_ready = !last || slot_free;
  assign take      = smp_valid && smp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      grp_valid  <= 1'b0;
    end else begin
      if (grp_valid && grp_ready) begin
        grp_valid <= 1'b0;
      end
      if (take) begin
        if (last) begin
          fill_count <= '0;
          grp_valid  <= 1'b1;
        end else begin
          fill_count <= fill_count + CNT_W'(1);
        end
      end
    end
    if (take) begin
      store <= {store[GROUP_SIZE-3:0], smp_data};
      if (last) begin
        grp_data <= {store, smp_data};
      end
    end
  end

endmodule

FILE: rtl/urm_median.sv
// urm_median: rank-select median of one group and the result output register.
// Depends on urm_pkg.
`timescale 1ns / 1ps

module urm_median #(
  parameter int GROUP_SIZE = urm_pkg::GROUP_SIZE_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            grp_valid,
  output logic                            grp_ready,
  input  urm_pkg::dist_t [GROUP_SIZE-1:0] grp_data,
  input  urm_pkg::dist_t                  lim,
  output logic                            out_valid,
  input  logic                            out_ready,
  output urm_pkg::dist_t                  median_cm,
  output logic                            out_of_range
);
  import urm_pkg::*;

  localparam int RANK_W = $clog2(GROUP_SIZE);
  localparam int MID    = GROUP_SIZE / 2;

  logic [RANK_W-1:0] rank [GROUP_SIZE];
  dist_t             med;

  // rank = number of elements ordered before this one, ties broken by position
  always_comb begin
    for (int i = 0; i < GROUP_SIZE; i++) begin
      rank[i] = '0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
        if (j != i) begin
          if (grp_data[j] < grp_data[i] || (grp_data[j] == grp_data[i] && j < i)) begin
            rank[i] = rank[i] + RANK_W'(1);
          end
        end
      end
    end
  end

  always_comb begin
    med = '0;
    for (int i = 0; i < GROUP_SIZE; i++) begin
      if (rank[i] == RANK_W'(MID)) begin
        med = grp_data[i];
      end
    end
  end

  assign grp_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (grp_ready) begin
      out_valid <= grp_valid;
    end
    if (grp_ready && grp_valid) begin
      median_cm    <= med;
      out_of_range <= (med > lim);
    end
  end

endmodule

FILE: rtl/urm_checker.sv
// urm_checker: port-level assertions for ultrasonic_range_median, bound to the top level.
// Depends on urm_pkg.
`timescale 1ns / 1ps

module urm_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input urm_pkg::dist_t median_cm,
  input logic           out_of_range
);
  import urm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(median_cm) && $stable(out_of_range))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word present right after reset");

  a_oor_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> median_cm != '0)
    else $error("out-of-range result with zero distance");

  a_no_block: assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("input blocked while output can drain");

endmodule

bind ultrasonic_range_median urm_checker u_urm_checker (.*);

FILE: dv/ultrasonic_range_median_test.sv
// Self-checking testbench for ultrasonic_range_median: echo widths in, group medians out.
// Depends on urm_pkg and the ultrasonic_range_median RTL; a built-in predictor checks each result.
`timescale 1ns / 1ps

module ultrasonic_range_median_test;
  import urm_pkg::*;

  localparam int GROUP_LEN = GROUP_SIZE_DEF;
  localparam int US_PER_CM = 58;
  localparam logic [APB_ADDR_W-1:0] ADDR_MAX_DIST = 3'd0;
  localparam logic [APB_ADDR_W-1:0] ADDR_UNUSED   = 3'd4;

  typedef struct packed {
    dist_t median;
    logic  far;
  } range_word_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  width_t                echo_width_us = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  dist_t                 median_cm;
  logic                  out_of_range;

  width_t      echo_backlog[$];
  range_word_t median_due[$];
  dist_t       range_max = dist_t'(MAX_DIST_RESET);
  int          group_fill = 0;
  dist_t       group_samples[GROUP_LEN];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          errors = 0;

  ultrasonic_range_median u_top (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .echo_width_us(echo_width_us),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .median_cm    (median_cm),
    .out_of_range (out_of_range)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(string what, int got, int want);
    $display("error at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // maxima above the ceiling behave as the ceiling
  function automatic int range_limit();
    return (range_max > dist_t'(MAX_DIST_CEIL)) ? MAX_DIST_CEIL : int'(range_max);
  endfunction

  function automatic dist_t to_cm(width_t w);
    int lim;
    int d;
    lim = range_limit();
    if (w == 0 || w > ECHO_TIMEOUT_US) return dist_t'(lim + 1);
    d = w / US_PER_CM;
    return (d > lim) ? dist_t'(lim + 1) : dist_t'(d);
  endfunction

  function automatic dist_t group_median();
    dist_t v[GROUP_LEN];
    dist_t key;
    int    i;
    int    j;
    v = group_samples;
    for (i = 1; i < GROUP_LEN; i++) begin
      key = v[i];
      j = i - 1;
      while (j >= 0 && v[j] > key) begin
        v[j + 1] = v[j];
        j--;
      end
      v[j + 1] = key;
    end
    return v[GROUP_LEN / 2];
  endfunction

  task automatic absorb_echo(width_t w);
    dist_t med;
    group_samples[group_fill] = to_cm(w);
    group_fill++;
    if (group_fill == GROUP_LEN) begin
      group_fill = 0;
      med = group_median();
      median_due.push_back(range_word_t'{med, int'(med) > range_limit()});
    end
  endtask

  // mostly in-range widths, plus no echo, timeouts, limit edges and raw noise
  function automatic width_t pick_width();
    int lim;
    int hi;
    int r;
    lim = range_limit();
    hi = (lim + 1) * US_PER_CM - 1;
    if (hi > ECHO_TIMEOUT_US) hi = ECHO_TIMEOUT_US;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 16) return width_t'($urandom_range(ECHO_TIMEOUT_US + 1, 32767));
    if (r < 30) return width_t'($urandom_range(32767));
    if (r < 42) return width_t'(lim * US_PER_CM + $urandom_range(115));
    return width_t'($urandom_range(hi, 1));
  endfunction

  task automatic drain();
    while (echo_backlog.size() != 0 || in_valid || median_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_access(logic [APB_ADDR_W-1:0] a, logic wr, logic [APB_DATA_W-1:0] d);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (!wr && prdata[DIST_W-1:0] !== range_max)
      report_mismatch("dist_limit readback", prdata[DIST_W-1:0], range_max);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // block must be idle; write, track, read back
  task automatic set_reg(logic [APB_ADDR_W-1:0] a, logic [APB_DATA_W-1:0] d);
    drain();
    apb_access(a, 1'b1, d);
    if (a == ADDR_MAX_DIST) range_max = dist_t'(d);
    apb_access(ADDR_MAX_DIST, 1'b0, '0);
  endtask

  task automatic random_phase(int n, int send_pct, int recv_pct, int chunk);
    int k;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (k = 0; k < n; k++) begin
      echo_backlog.push_back(pick_width());
      if (chunk > 0 && (k % chunk) == chunk - 1) drain();
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) absorb_echo(echo_width_us);
      if (!in_valid || in_ready) begin
        if (echo_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid      <= 1'b1;
          echo_width_us <= echo_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    range_word_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (median_due.size() == 0) begin
          report_mismatch("unexpected word, median_cm", median_cm, 0);
        end else begin
          want = median_due.pop_front();
          if (median_cm !== want.median) report_mismatch("median_cm", median_cm, want.median);
          if (out_of_range !== want.far) report_mismatch("out_of_range", out_of_range, want.far);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    int p;
    int cfg;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    apb_access(ADDR_MAX_DIST, 1'b0, '0);

    // reset maximum 250: no echo, divisor edges, limit edges, timeout edges
    echo_backlog = '{15'd0, 15'd1, 15'd57, 15'd58, 15'd59,
                     15'd14500, 15'd14557, 15'd14558, 15'd29999, 15'd30000};
    set_reg(ADDR_MAX_DIST, 32'd510);
    echo_backlog = '{15'd29580, 15'd29637, 15'd29638, 15'd30000, 15'd30001};
    set_reg(ADDR_MAX_DIST, 32'd0);
    echo_backlog = '{15'd1, 15'd57, 15'd58, 15'd0, 15'h7FFF};
    // 511 acts as 510; maximum changes in the middle of a group
    set_reg(ADDR_MAX_DIST, 32'hFFFF_FFFF);
    echo_backlog = '{15'd29580, 15'd1000, 15'd0};
    set_reg(ADDR_MAX_DIST, 32'd1);
    echo_backlog = '{15'd58, 15'd116};
    // unmapped register must not disturb the maximum
    set_reg(ADDR_UNUSED, 32'd77);

    for (p = 0; p < 8; p++) begin
      case (p)
        0: cfg = 1;
        1: cfg = 510;
        2: cfg = 511;
        3: cfg = $urandom_range(509, 2);
        4: cfg = 0;
        5: cfg = 250;
        6: cfg = $urandom_range(511);
        default: cfg = $urandom_range(400, 60) | 32'hFFFF_FE00;
      endcase
      set_reg(ADDR_MAX_DIST, cfg);
      case (p % 4)
        0: random_phase($urandom_range(63, 50), 0, 0, (p == 4) ? 7 : 0);
        1: random_phase($urandom_range(63, 50), 58, 0, 0);
        2: random_phase($urandom_range(63, 50), 0, 58, 0);
        default: random_phase($urandom_range(63, 50), 17, 17, 0);
      endcase
    end

    drain();
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Mismatches found");
    $finish;
  end

endmodule
